>>> rtl/pppd_pkg.sv
// shared types, register codes and helpers for the packed pixel palette decoder
`timescale 1ns / 1ps
package pppd_pkg;

  localparam int NUM_PIX = 8;
  localparam int PIX_W   = 4;
  localparam int BYTE_W  = 8;
  localparam int PAL_W   = 64;
  localparam int CNT_W   = 4;
  localparam int MODE_W  = 3;
  localparam int MASK_W  = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [MODE_W-1:0] MODE_MONO640  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FOUR320  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SIXT160  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SIXT320  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PLANE640 = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MONO720  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOUR_MASK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_TABLE = 2'd2;

  localparam logic [CNT_W-1:0] CNT_TWO   = 4'd2;
  localparam logic [CNT_W-1:0] CNT_FOUR  = 4'd4;
  localparam logic [CNT_W-1:0] CNT_EIGHT = 4'd8;

  localparam logic [PIX_W-1:0] MONO_ON  = 4'd7;
  localparam logic [PIX_W-1:0] MONO_OFF = 4'd0;

  // masked raw indices for one byte, handed from unpack to lookup
  typedef struct packed {
    logic [NUM_PIX-1:0][PIX_W-1:0] idx;
    logic [CNT_W-1:0]              count;
    logic                          mono;
  } pix_word_t;

  typedef logic [NUM_PIX-1:0][PIX_W-1:0] pix_vec_t;

  function automatic logic [PIX_W-1:0] pal_entry(input logic [PAL_W-1:0] tbl,
                                                 input logic [PIX_W-1:0] idx);
    return tbl[{idx, 2'b00} +: PIX_W];
  endfunction

endpackage

>>> rtl/pppd_if.sv
// handshake channel interfaces: pixel byte input, decoded result, register write
`timescale 1ns / 1ps
interface pppd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] plane_byte_low;
  logic [7:0] plane_byte_high;
  modport source (output valid, plane_byte_low, plane_byte_high, input ready);
  modport sink   (input valid, plane_byte_low, plane_byte_high, output ready);
endinterface

interface pppd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] pixel_0;
  logic [3:0] pixel_1;
  logic [3:0] pixel_2;
  logic [3:0] pixel_3;
  logic [3:0] pixel_4;
  logic [3:0] pixel_5;
  logic [3:0] pixel_6;
  logic [3:0] pixel_7;
  logic [3:0] pixel_count;
  modport source (output valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
                  pixel_6, pixel_7, pixel_count, input ready);
  modport sink   (input valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
                  pixel_6, pixel_7, pixel_count, output ready);
endinterface

interface pppd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/pppd_unpack.sv
// splits a fetched byte into masked raw pixel indices by mode
`timescale 1ns / 1ps
module pppd_unpack (
  input  logic [pppd_pkg::MODE_W-1:0] pixel_mode,
  input  logic [pppd_pkg::MASK_W-1:0] colour_mask,
  input  logic [pppd_pkg::BYTE_W-1:0] byte_lo,
  input  logic [pppd_pkg::BYTE_W-1:0] byte_hi,
  output pppd_pkg::pix_word_t         word
);
  import pppd_pkg::*;

  always_comb begin
    word = '0;
    case (pixel_mode)
      MODE_FOUR320: begin
        word.count = CNT_FOUR;
        for (int i = 0; i < 4; i++) begin
          word.idx[i] = {2'b00, byte_lo[7-2*i -: 2] & colour_mask[1:0]};
        end
      end
      MODE_SIXT160, MODE_SIXT320: begin
        word.count  = CNT_TWO;
        word.idx[0] = byte_lo[7:4] & colour_mask;
        word.idx[1] = byte_lo[3:0] & colour_mask;
      end
      MODE_PLANE640: begin
        word.count = CNT_EIGHT;
        for (int i = 0; i < NUM_PIX; i++) begin
          word.idx[i] = {2'b00, byte_hi[7-i] & colour_mask[1], byte_lo[7-i] & colour_mask[0]};
        end
      end
      MODE_MONO720: begin
        // mask ignored, fixed two-entry palette
        word.count = CNT_EIGHT;
        word.mono  = 1'b1;
        for (int i = 0; i < NUM_PIX; i++) begin
          word.idx[i] = {3'b000, byte_lo[7-i]};
        end
      end
      default: begin
        // mono640, and the undefined modes decode the same
        word.count = CNT_EIGHT;
        for (int i = 0; i < NUM_PIX; i++) begin
          word.idx[i] = {3'b000, byte_lo[7-i] & colour_mask[0]};
        end
      end
    endcase
  end

endmodule

>>> rtl/pppd_lookup.sv
// maps masked indices through the palette and zeroes unused pixel slots
`timescale 1ns / 1ps
module pppd_lookup (
  input  pppd_pkg::pix_word_t        word,
  input  logic [pppd_pkg::PAL_W-1:0] palette_table,
  output pppd_pkg::pix_vec_t         pix
);
  import pppd_pkg::*;

  always_comb begin
    for (int i = 0; i < NUM_PIX; i++) begin
      if (CNT_W'(i) >= word.count) begin
        pix[i] = '0;
      end else if (word.mono) begin
        pix[i] = word.idx[i][0] ? MONO_ON : MONO_OFF;
      end else begin
        pix[i] = pal_entry(palette_table, word.idx[i]);
      end
    end
  end

endmodule

>>> rtl/packed_pixel_palette_decoder_unit.sv
// top level: config registers and three-stage decode pipeline
//
//  channel | dir | handshake   | payload
//  in_ch   | in  | valid/ready | plane_byte_low, plane_byte_high
//  out_ch  | out | valid/ready | pixel_0..pixel_7, pixel_count
//  cfg_ch  | in  | valid/ready | index (0 mode, 1 mask, 2 palette), data
//
// three register stages: input capture, unpack and mask, palette lookup.
// one request per cycle sustained while the output is not stalled.
// rst_n clears the valid bits and the config registers (all to zero).
// a stage moves when it is empty or the next one moves, so a stall at the
// output backs up through the stages without losing or repeating a request.
`timescale 1ns / 1ps
module packed_pixel_palette_decoder_unit (
  input  logic              clk,
  input  logic              rst_n,
  pppd_in_if.sink           in_ch,
  pppd_out_if.source        out_ch,
  pppd_cfg_if.sink          cfg_ch
);
  import pppd_pkg::*;

  logic [MODE_W-1:0] pixel_mode_r;
  logic [MASK_W-1:0] colour_mask_r;
  logic [PAL_W-1:0]  palette_table_r;

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_lo_r;
  logic [BYTE_W-1:0] s1_hi_r;
  logic              s2_valid_r;
  pix_word_t         s2_word_r;
  logic              out_valid_r;
  pix_vec_t          out_pix_r;
  logic [CNT_W-1:0]  out_count_r;

  pix_word_t word_nxt;
  pix_vec_t  pix_nxt;
  logic      out_move;
  logic      s2_move;
  logic      s1_move;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_mode_r    <= MODE_MONO640;
      colour_mask_r   <= '0;
      palette_table_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_PIXEL_MODE:    pixel_mode_r    <= cfg_ch.data[MODE_W-1:0];
        REG_COLOUR_MASK:   colour_mask_r   <= cfg_ch.data[MASK_W-1:0];
        REG_PALETTE_TABLE: palette_table_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign out_move    = !out_valid_r || out_ch.ready;
  assign s2_move     = !s2_valid_r || out_move;
  assign s1_move     = !s1_valid_r || s2_move;
  assign in_ch.ready = s1_move;

  pppd_unpack u_unpack (
    .pixel_mode  (pixel_mode_r),
    .colour_mask (colour_mask_r),
    .byte_lo     (s1_lo_r),
    .byte_hi     (s1_hi_r),
    .word        (word_nxt)
  );

  pppd_lookup u_lookup (
    .word          (s2_word_r),
    .palette_table (palette_table_r),
    .pix           (pix_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_move) s1_valid_r <= in_ch.valid;
      if (s2_move) s2_valid_r <= s1_valid_r;
      if (out_move) out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && in_ch.valid) begin
      s1_lo_r <= in_ch.plane_byte_low;
      s1_hi_r <= in_ch.plane_byte_high;
    end
    if (s2_move && s1_valid_r) begin
      s2_word_r <= word_nxt;
    end
    if (out_move && s2_valid_r) begin
      out_pix_r   <= pix_nxt;
      out_count_r <= s2_word_r.count;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_0     = out_pix_r[0];
  assign out_ch.pixel_1     = out_pix_r[1];
  assign out_ch.pixel_2     = out_pix_r[2];
  assign out_ch.pixel_3     = out_pix_r[3];
  assign out_ch.pixel_4     = out_pix_r[4];
  assign out_ch.pixel_5     = out_pix_r[5];
  assign out_ch.pixel_6     = out_pix_r[6];
  assign out_ch.pixel_7     = out_pix_r[7];
  assign out_ch.pixel_count = out_count_r;

  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.pixel_count == CNT_TWO || out_ch.pixel_count == CNT_FOUR ||
                      out_ch.pixel_count == CNT_EIGHT))
    else $error("pixel_count not 2, 4 or 8");

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.pixel_count == CNT_TWO) |->
      (out_ch.pixel_2 == '0 && out_ch.pixel_3 == '0 && out_ch.pixel_4 == '0 &&
       out_ch.pixel_5 == '0 && out_ch.pixel_6 == '0 && out_ch.pixel_7 == '0))
    else $error("unused pixel slot not zero");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> s1_valid_r)
    else $error("accepted request missing from first stage");

  a_stall_holds_s2: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !out_move) |=> (s2_valid_r && $stable(s2_word_r)))
    else $error("second stage changed while stalled");

endmodule

>>> tb/sv/packed_pixel_palette_decoder_unit_tb.sv
// testbench for the packed pixel palette decoder: directed and random decode checks
`timescale 1ns / 1ps
module packed_pixel_palette_decoder_unit_tb;
  import pppd_pkg::*;

  localparam int PIPE_LATENCY   = 6;
  localparam int BACKLOG_CYCLES = 80;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 66;

  // codes the package does not name
  localparam logic [MODE_W-1:0]    MODE_UNDEF6 = 3'd6;
  localparam logic [MODE_W-1:0]    MODE_UNDEF7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

  localparam logic [PAL_W-1:0] PAL_IDENTITY = 64'hFEDC_BA98_7654_3210;
  localparam logic [PAL_W-1:0] PAL_ONES     = '1;

  typedef struct packed {
    pix_vec_t         pix;
    logic [CNT_W-1:0] count;
  } pixel_row_t;

  logic clk;
  logic rst_n;

  pppd_in_if  in_bus();
  pppd_out_if out_bus();
  pppd_cfg_if cfg_bus();

  packed_pixel_palette_decoder_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // mirror of the register file
  logic [MODE_W-1:0] mode_reg;
  logic [MASK_W-1:0] mask_reg;
  logic [PAL_W-1:0]  palette_reg;

  pixel_row_t expected_rows[$];
  int         mismatch_count;
  bit         steady;
  bit         backlog_wanted;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [PIX_W-1:0] lookup_colour(input logic [PIX_W-1:0] raw);
    return palette_reg[raw * PIX_W +: PIX_W];
  endfunction

  function automatic pixel_row_t decode_byte(input logic [BYTE_W-1:0] lo,
                                             input logic [BYTE_W-1:0] hi);
    pixel_row_t row;
    row.pix   = '0;
    row.count = CNT_EIGHT;
    case (mode_reg)
      MODE_FOUR320: begin
        row.count = CNT_FOUR;
        for (int i = 0; i < 4; i++)
          row.pix[i] = lookup_colour({2'b00, lo[6 - 2 * i +: 2]} & mask_reg);
      end
      MODE_SIXT160, MODE_SIXT320: begin
        row.count  = CNT_TWO;
        row.pix[0] = lookup_colour(lo[7:4] & mask_reg);
        row.pix[1] = lookup_colour(lo[3:0] & mask_reg);
      end
      MODE_PLANE640: begin
        for (int i = 0; i < NUM_PIX; i++)
          row.pix[i] = lookup_colour({2'b00, hi[7 - i], lo[7 - i]} & mask_reg);
      end
      MODE_MONO720: begin
        // fixed black/white, mask and palette not used
        for (int i = 0; i < NUM_PIX; i++)
          row.pix[i] = lo[7 - i] ? MONO_ON : MONO_OFF;
      end
      default: begin
        // mono640 and the undefined modes
        for (int i = 0; i < NUM_PIX; i++)
          row.pix[i] = lookup_colour({3'b000, lo[7 - i]} & mask_reg);
      end
    endcase
    return row;
  endfunction

  function automatic int rand_gap();
    int roll;
    if (steady)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65)
      return 0;
    if (roll < 95)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // result receiver: random stalls plus one long hold-off on demand
  initial begin
    int gap;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (backlog_wanted) begin
        backlog_wanted = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (BACKLOG_CYCLES) @(posedge clk);
      end else begin
        gap = rand_gap();
        if (gap == 0) begin
          out_bus.ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_bus.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    pixel_row_t got;
    pixel_row_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.pix[0] = out_bus.pixel_0;
      got.pix[1] = out_bus.pixel_1;
      got.pix[2] = out_bus.pixel_2;
      got.pix[3] = out_bus.pixel_3;
      got.pix[4] = out_bus.pixel_4;
      got.pix[5] = out_bus.pixel_5;
      got.pix[6] = out_bus.pixel_6;
      got.pix[7] = out_bus.pixel_7;
      got.count  = out_bus.pixel_count;
      if (expected_rows.size() == 0) begin
        note_mismatch("result with no request pending, pixel_count", int'(got.count), 0);
      end else begin
        want = expected_rows.pop_front();
        for (int i = 0; i < NUM_PIX; i++)
          if (got.pix[i] !== want.pix[i])
            note_mismatch($sformatf("pixel_%0d", i), int'(got.pix[i]), int'(want.pix[i]));
        if (got.count !== want.count)
          note_mismatch("pixel_count", int'(got.count), int'(want.count));
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid           <= 1'b1;
    in_bus.plane_byte_low  <= lo;
    in_bus.plane_byte_high <= hi;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    expected_rows.push_back(decode_byte(lo, hi));
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  // leaves cfg valid high so back-to-back writes follow without a gap
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAL_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      REG_PIXEL_MODE:    mode_reg    = data[MODE_W-1:0];
      REG_COLOUR_MASK:   mask_reg    = data[MASK_W-1:0];
      REG_PALETTE_TABLE: palette_reg = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [PAL_W-1:0] mode_data,
                           input logic [PAL_W-1:0] mask_data,
                           input logic [PAL_W-1:0] palette_data);
    wait_idle();
    write_reg(REG_PIXEL_MODE, mode_data);
    write_reg(REG_COLOUR_MASK, mask_data);
    write_reg(REG_PALETTE_TABLE, palette_data);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    // all registers zero: every pixel is palette entry 0
    send_byte(8'hFF, 8'hFF);
    send_byte(8'h5A, 8'hA5);
  endtask

  task automatic test_each_mode();
    logic [MODE_W-1:0] modes[8];
    modes = '{MODE_MONO640, MODE_FOUR320, MODE_SIXT160, MODE_SIXT320,
              MODE_PLANE640, MODE_MONO720, MODE_UNDEF6, MODE_UNDEF7};
    foreach (modes[m]) begin
      configure(PAL_W'(modes[m]), 64'hF, PAL_IDENTITY);
      send_byte(8'hFF, 8'h00);
      send_byte(8'hA5, 8'h3C);
    end
  endtask

  task automatic test_mask_palette_extremes();
    configure(PAL_W'(MODE_PLANE640), 64'h0, PAL_ONES);
    send_byte(8'hFF, 8'hFF);
    configure(PAL_W'(MODE_PLANE640), 64'hF, 64'h0);
    send_byte(8'hC3, 8'h96);
    configure(PAL_W'(MODE_PLANE640), 64'h2, PAL_IDENTITY);
    send_byte(8'hF0, 8'hCC);
  endtask

  task automatic test_unused_register();
    // a write past the register list must leave the decode unchanged
    wait_idle();
    write_reg(REG_UNUSED, PAL_ONES);
    cfg_bus.valid <= 1'b0;
    send_byte(8'h0F, 8'hF0);
  endtask

  task automatic random_config();
    logic [PAL_W-1:0] pal;
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0)
      pal = '0;
    else if (roll == 1)
      pal = PAL_ONES;
    else
      pal = {$urandom, $urandom};
    // upper data bits are junk on purpose
    configure({$urandom, $urandom}, {$urandom, $urandom}, pal);
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_config();
      steady = (p % 4 == 3);
      repeat (PHASE_ITEMS)
        send_byte(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
      steady = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    random_config();
    steady         = 1'b1;
    backlog_wanted = 1'b1;
    repeat (40)
      send_byte(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
    steady = 1'b0;
  endtask

  initial begin
    mode_reg       = '0;
    mask_reg       = '0;
    palette_reg    = '0;
    mismatch_count = 0;
    steady         = 1'b0;
    backlog_wanted = 1'b0;
    rst_n                  <= 1'b0;
    in_bus.valid           <= 1'b0;
    in_bus.plane_byte_low  <= '0;
    in_bus.plane_byte_high <= '0;
    cfg_bus.valid          <= 1'b0;
    cfg_bus.index          <= '0;
    cfg_bus.data           <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_each_mode();
    test_mask_palette_extremes();
    test_unused_register();
    test_random_traffic();
    test_backpressure();

    wait_idle();
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
